FILE: rtl/gtd_pkg.sv
// ----------------------------------------------------------------------------
// gtd_pkg
// Shared types and constants of the Goertzel tone detector: field widths,
// register codes, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package gtd_pkg;

  localparam int ACC_W   = 48;  // q1/q2 accumulators
  localparam int HALF_W  = 24;  // accumulator half fed to the multiplier
  localparam int MULA_W  = 25;  // signed multiplier operand A
  localparam int COEF_W  = 16;  // coefficient registers
  localparam int PROD_W  = 41;  // MULA_W + COEF_W
  localparam int FULL_W  = 64;  // full 48x16 product
  localparam int SUM_W   = 51;  // recurrence sum before saturation
  localparam int NUM_W   = 51;  // numerator fed to the divider
  localparam int LEN_W   = 13;  // block length and sample count
  localparam int OUT_W   = 24;  // result fields
  localparam int RSH_W   = 14;  // Q2.14 product shift
  localparam int TSH_W   = 15;  // Q1.15 product shift
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam int MAX_BLOCK = 4096;

  localparam logic [LEN_W-1:0]  MAX_BLOCK_LEN = LEN_W'(MAX_BLOCK);
  localparam logic [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [OUT_W-1:0]  OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0]  OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_RECUR_COEFF  = 2'd0;
  localparam logic [1:0] REG_COS_TERM     = 2'd1;
  localparam logic [1:0] REG_SIN_TERM     = 2'd2;
  localparam logic [1:0] REG_BLOCK_LENGTH = 2'd3;

  localparam logic [COEF_W-1:0] RECUR_COEFF_RST  = 16'sd0;
  localparam logic [COEF_W-1:0] COS_TERM_RST     = 16'sd32767;
  localparam logic [COEF_W-1:0] SIN_TERM_RST     = 16'sd0;
  localparam logic [LEN_W-1:0]  BLOCK_LENGTH_RST = 13'd256;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_HI,
    S_UPDATE,
    S_RE_LO,
    S_RE_HI,
    S_RE_START,
    S_RE_WAIT,
    S_IM_LO,
    S_IM_HI,
    S_IM_START,
    S_IM_WAIT,
    S_EMIT
  } gtd_state_e;

  typedef enum logic {
    SRC_Q1,
    SRC_Q2
  } gtd_src_e;

  typedef enum logic [1:0] {
    COEF_RECUR,
    COEF_COS,
    COEF_SIN
  } gtd_coef_e;

  typedef struct packed {
    logic      take_sample;
    logic      mul_en;
    logic      mul_hi;
    gtd_src_e  mul_src;
    gtd_coef_e mul_coef;
    logic      update;
    logic      div_start;
    logic      div_im;
    logic      emit;
  } gtd_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
  } gtd_sts_t;

endpackage

`default_nettype wire

FILE: rtl/gtd_if.sv
// ----------------------------------------------------------------------------
// gtd_if
// Valid/ready channels of the tone detector: sample words in, result
// words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gtd_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gtd_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [gtd_pkg::OUT_W-1:0] real_part;
  logic signed [gtd_pkg::OUT_W-1:0] imag_part;

  modport source (output valid, output real_part, output imag_part, input ready);
  modport sink   (input valid, input real_part, input imag_part, output ready);
endinterface

`default_nettype wire

FILE: rtl/gtd_div.sv
// ----------------------------------------------------------------------------
// gtd_div
// Restoring divider, one quotient bit per cycle. Truncates toward zero and
// saturates the quotient to the result width.
// ----------------------------------------------------------------------------
`default_nettype none

module gtd_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire logic signed [gtd_pkg::NUM_W-1:0]    num_i,
  input  wire logic        [gtd_pkg::LEN_W-1:0]    den_i,
  output      logic                                done_o,
  output      logic signed [gtd_pkg::OUT_W-1:0]    quot_o
);

  localparam int NUM_W = gtd_pkg::NUM_W;
  localparam int LEN_W = gtd_pkg::LEN_W;
  localparam int OUT_W = gtd_pkg::OUT_W;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] quo_q, quo_d;
  logic [LEN_W-1:0] rem_q, rem_d;
  logic [LEN_W-1:0] den_q, den_d;
  logic             neg_q, neg_d;

  logic [NUM_W-1:0] mag;
  logic [LEN_W:0]   trial;
  logic             fits;
  logic             too_big;

  assign mag   = num_i[NUM_W-1] ? (~num_i + NUM_W'(1)) : num_i;
  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = mag;
      rem_d  = '0;
      den_d  = den_i;
      neg_d  = num_i[NUM_W-1];
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = fits ? LEN_W'(trial - {1'b0, den_q}) : trial[LEN_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // a negative quotient may reach one step further than a positive one
  always_comb begin
    if (neg_q) begin
      too_big = (|quo_q[NUM_W-1:OUT_W]) || (quo_q[OUT_W-1] && (|quo_q[OUT_W-2:0]));
      quot_o  = too_big ? gtd_pkg::OUT_MIN : OUT_W'(~quo_q + NUM_W'(1));
    end else begin
      too_big = |quo_q[NUM_W-1:OUT_W-1];
      quot_o  = too_big ? gtd_pkg::OUT_MAX : quo_q[OUT_W-1:0];
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

FILE: rtl/gtd_dp.sv
// ----------------------------------------------------------------------------
// gtd_dp
// Datapath: q1/q2 accumulators, shared 25x16 multiplier with a 64-bit
// product register, recurrence update with saturation, the divider and
// the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gtd_dp #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire gtd_pkg::gtd_cmd_t                     cmd_i,
  output      gtd_pkg::gtd_sts_t                     sts_o,
  input  wire logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  wire logic signed [gtd_pkg::COEF_W-1:0]     recur_coeff_i,
  input  wire logic signed [gtd_pkg::COEF_W-1:0]     cos_term_i,
  input  wire logic signed [gtd_pkg::COEF_W-1:0]     sin_term_i,
  input  wire logic        [gtd_pkg::LEN_W-1:0]      block_length_i,
  output      logic signed [gtd_pkg::OUT_W-1:0]      real_part_o,
  output      logic signed [gtd_pkg::OUT_W-1:0]      imag_part_o
);

  localparam int ACC_W  = gtd_pkg::ACC_W;
  localparam int HALF_W = gtd_pkg::HALF_W;
  localparam int MULA_W = gtd_pkg::MULA_W;
  localparam int COEF_W = gtd_pkg::COEF_W;
  localparam int PROD_W = gtd_pkg::PROD_W;
  localparam int FULL_W = gtd_pkg::FULL_W;
  localparam int SUM_W  = gtd_pkg::SUM_W;
  localparam int NUM_W  = gtd_pkg::NUM_W;
  localparam int LEN_W  = gtd_pkg::LEN_W;
  localparam int OUT_W  = gtd_pkg::OUT_W;
  localparam int RSH_W  = gtd_pkg::RSH_W;
  localparam int TSH_W  = gtd_pkg::TSH_W;

  logic signed [ACC_W-1:0]       q1_q, q1_d, q2_q, q2_d;
  logic        [LEN_W-1:0]       count_q, count_d;
  logic signed [FULL_W-1:0]      acc_q, acc_d;
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [OUT_W-1:0]       re_q, im_q, out_re_q, out_im_q;

  logic signed [ACC_W-1:0]  mul_src;
  logic signed [MULA_W-1:0] mul_a;
  logic signed [COEF_W-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [FULL_W-1:0] prod_ext;
  logic signed [SUM_W-1:0]  sum;
  logic signed [ACC_W-1:0]  q0_sat;
  logic signed [NUM_W-1:0]  num_re, num_im;
  logic        [LEN_W-1:0]  n_eff;
  logic                     div_done;
  logic signed [OUT_W-1:0]  div_quot;

  // multiplier: low half unsigned, high half signed, one half per cycle
  assign mul_src = (cmd_i.mul_src == gtd_pkg::SRC_Q1) ? q1_q : q2_q;
  assign mul_a   = cmd_i.mul_hi ? {mul_src[ACC_W-1], mul_src[ACC_W-1:HALF_W]}
                                : {1'b0, mul_src[HALF_W-1:0]};

  always_comb begin
    case (cmd_i.mul_coef)
      gtd_pkg::COEF_RECUR: mul_b = recur_coeff_i;
      gtd_pkg::COEF_COS:   mul_b = cos_term_i;
      gtd_pkg::COEF_SIN:   mul_b = sin_term_i;
      default:             mul_b = '0;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = {{(FULL_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.mul_en) begin
      acc_d = cmd_i.mul_hi ? (acc_q + (prod_ext <<< HALF_W)) : prod_ext;
    end
  end

  // q0 = (coeff*q1 >>> 14) - q2 + x, clamped to the accumulator range
  assign sum = {acc_q[FULL_W-1], acc_q[FULL_W-1:RSH_W]}
             - {{(SUM_W-ACC_W){q2_q[ACC_W-1]}}, q2_q}
             + {{(SUM_W-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};

  always_comb begin
    if ((sum[SUM_W-1:ACC_W-1] == '0) || (sum[SUM_W-1:ACC_W-1] == '1)) begin
      q0_sat = sum[ACC_W-1:0];
    end else begin
      q0_sat = sum[SUM_W-1] ? gtd_pkg::ACC_MIN : gtd_pkg::ACC_MAX;
    end
  end

  assign n_eff = (block_length_i == '0) ? LEN_W'(1)
               : (block_length_i > gtd_pkg::MAX_BLOCK_LEN) ? gtd_pkg::MAX_BLOCK_LEN
               : block_length_i;

  assign sts_o.last = ({1'b0, count_q} + (LEN_W+1)'(1)) >= {1'b0, n_eff};

  always_comb begin
    q1_d    = q1_q;
    q2_d    = q2_q;
    count_d = count_q;
    if (cmd_i.update) begin
      q1_d    = q0_sat;
      q2_d    = q1_q;
      count_d = count_q + LEN_W'(1);
    end else if (cmd_i.emit) begin
      q1_d    = '0;
      q2_d    = '0;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q1_q    <= '0;
      q2_q    <= '0;
      count_q <= '0;
    end else begin
      q1_q    <= q1_d;
      q2_q    <= q2_d;
      count_q <= count_d;
    end
  end

  // numerators from the q2*cos or q2*sin product, shifted by 15
  assign num_im = {{(NUM_W-(FULL_W-TSH_W)){acc_q[FULL_W-1]}}, acc_q[FULL_W-1:TSH_W]};
  assign num_re = {{(NUM_W-ACC_W){q1_q[ACC_W-1]}}, q1_q} - num_im;

  gtd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (cmd_i.div_im ? num_im : num_re),
    .den_i   (n_eff),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign sts_o.div_done = div_done;

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.take_sample) begin
      x_q <= sample_i;
    end
    if (div_done && !cmd_i.div_im) begin
      re_q <= div_quot;
    end
    if (div_done && cmd_i.div_im) begin
      im_q <= div_quot;
    end
    if (cmd_i.emit) begin
      out_re_q <= re_q;
      out_im_q <= im_q;
    end
  end

  assign real_part_o = out_re_q;
  assign imag_part_o = out_im_q;

endmodule

`default_nettype wire

FILE: rtl/gtd_ctrl.sv
// ----------------------------------------------------------------------------
// gtd_ctrl
// Sequencer: steps the datapath through the per-sample recurrence and the
// end-of-block scaling, and owns the handshake on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module gtd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      gtd_pkg::gtd_cmd_t cmd_o,
  input  wire gtd_pkg::gtd_sts_t sts_i
);

  gtd_pkg::gtd_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gtd_pkg::S_IDLE:     if (in_valid_i) begin
                             state_d = gtd_pkg::S_MUL_HI;
                           end
      gtd_pkg::S_MUL_HI:   state_d = gtd_pkg::S_UPDATE;
      gtd_pkg::S_UPDATE:   state_d = sts_i.last ? gtd_pkg::S_RE_LO : gtd_pkg::S_IDLE;
      gtd_pkg::S_RE_LO:    state_d = gtd_pkg::S_RE_HI;
      gtd_pkg::S_RE_HI:    state_d = gtd_pkg::S_RE_START;
      gtd_pkg::S_RE_START: state_d = gtd_pkg::S_RE_WAIT;
      gtd_pkg::S_RE_WAIT:  if (sts_i.div_done) begin
                             state_d = gtd_pkg::S_IM_LO;
                           end
      gtd_pkg::S_IM_LO:    state_d = gtd_pkg::S_IM_HI;
      gtd_pkg::S_IM_HI:    state_d = gtd_pkg::S_IM_START;
      gtd_pkg::S_IM_START: state_d = gtd_pkg::S_IM_WAIT;
      gtd_pkg::S_IM_WAIT:  if (sts_i.div_done) begin
                             state_d = gtd_pkg::S_EMIT;
                           end
      gtd_pkg::S_EMIT:     if (out_free) begin
                             state_d = gtd_pkg::S_IDLE;
                           end
      default:             state_d = gtd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.mul_src  = gtd_pkg::SRC_Q1;
    cmd_o.mul_coef = gtd_pkg::COEF_RECUR;
    in_ready_o     = 1'b0;
    unique case (state_q)
      gtd_pkg::S_IDLE: begin
        // low half of coeff*q1 goes in the same cycle as the sample
        in_ready_o        = 1'b1;
        cmd_o.take_sample = in_valid_i;
        cmd_o.mul_en      = in_valid_i;
      end
      gtd_pkg::S_MUL_HI: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_hi = 1'b1;
      end
      gtd_pkg::S_UPDATE: cmd_o.update = 1'b1;
      gtd_pkg::S_RE_LO: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_src  = gtd_pkg::SRC_Q2;
        cmd_o.mul_coef = gtd_pkg::COEF_COS;
      end
      gtd_pkg::S_RE_HI: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_hi   = 1'b1;
        cmd_o.mul_src  = gtd_pkg::SRC_Q2;
        cmd_o.mul_coef = gtd_pkg::COEF_COS;
      end
      gtd_pkg::S_RE_START: cmd_o.div_start = 1'b1;
      gtd_pkg::S_RE_WAIT:  cmd_o.div_im = 1'b0;
      gtd_pkg::S_IM_LO: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_src  = gtd_pkg::SRC_Q2;
        cmd_o.mul_coef = gtd_pkg::COEF_SIN;
      end
      gtd_pkg::S_IM_HI: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_hi   = 1'b1;
        cmd_o.mul_src  = gtd_pkg::SRC_Q2;
        cmd_o.mul_coef = gtd_pkg::COEF_SIN;
      end
      gtd_pkg::S_IM_START: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_im    = 1'b1;
      end
      gtd_pkg::S_IM_WAIT: cmd_o.div_im = 1'b1;
      gtd_pkg::S_EMIT:    cmd_o.emit = out_free;
      default:            cmd_o = '0;
    endcase
  end

  // hold the result word until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gtd_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == gtd_pkg::S_RE_WAIT || state_q == gtd_pkg::S_IM_WAIT))
    else $error("divider finished outside a wait state");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("result word not presented after emit");

  a_re_then_im: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gtd_pkg::S_RE_WAIT && sts_i.div_done) |=> state_q == gtd_pkg::S_IM_LO)
    else $error("imaginary part not started after real part");

endmodule

`default_nettype wire

FILE: rtl/goertzel_tone_detector_unit.sv
// ----------------------------------------------------------------------------
// goertzel_tone_detector_unit
// Fixed-point Goertzel single-tone detector with an APB register port.
// ----------------------------------------------------------------------------
// For each accepted sample the shared 25x16 multiplier forms the 48x16
// product coeff*q1 in two halves, then the recurrence update runs. At the
// end of a block the same multiplier forms q2*cos and q2*sin, and a
// one-bit-per-cycle divider divides q1 - q2*cos and q2*sin by N, so after
// the last sample of a block the next sample is taken only after both
// divisions, plus any wait for the sink to take the previous result.
// The result word sits in an output register, so sampling resumes while it
// waits. Block length 0 counts as 1 and lengths above 4096 are clamped.
// Registers at byte offsets 0x0 recur_coeff (Q2.14), 0x4 cos_term (Q1.15),
// 0x8 sin_term (Q1.15), 0xC block_length; write only between samples.
// ----------------------------------------------------------------------------
`default_nettype none

module goertzel_tone_detector_unit #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gtd_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [gtd_pkg::DATA_W-1:0]    pwdata,
  output      logic [gtd_pkg::DATA_W-1:0]    prdata,
  output      logic                          pready,
  gtd_in_if.sink                             in_if,
  gtd_out_if.source                          out_if
);

  localparam int COEF_W = gtd_pkg::COEF_W;
  localparam int LEN_W  = gtd_pkg::LEN_W;
  localparam int DATA_W = gtd_pkg::DATA_W;

  logic [COEF_W-1:0] recur_coeff_q, cos_term_q, sin_term_q;
  logic [LEN_W-1:0]  block_length_q;
  logic              wr_en;
  logic [1:0]        reg_idx;

  gtd_pkg::gtd_cmd_t cmd;
  gtd_pkg::gtd_sts_t sts;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[gtd_pkg::ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recur_coeff_q  <= gtd_pkg::RECUR_COEFF_RST;
      cos_term_q     <= gtd_pkg::COS_TERM_RST;
      sin_term_q     <= gtd_pkg::SIN_TERM_RST;
      block_length_q <= gtd_pkg::BLOCK_LENGTH_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        gtd_pkg::REG_RECUR_COEFF:  recur_coeff_q  <= pwdata[COEF_W-1:0];
        gtd_pkg::REG_COS_TERM:     cos_term_q     <= pwdata[COEF_W-1:0];
        gtd_pkg::REG_SIN_TERM:     sin_term_q     <= pwdata[COEF_W-1:0];
        gtd_pkg::REG_BLOCK_LENGTH: block_length_q <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gtd_pkg::REG_RECUR_COEFF:  prdata = DATA_W'(recur_coeff_q);
      gtd_pkg::REG_COS_TERM:     prdata = DATA_W'(cos_term_q);
      gtd_pkg::REG_SIN_TERM:     prdata = DATA_W'(sin_term_q);
      gtd_pkg::REG_BLOCK_LENGTH: prdata = DATA_W'(block_length_q);
      default:                   prdata = '0;
    endcase
  end

  gtd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gtd_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       (in_if.sample),
    .recur_coeff_i  (recur_coeff_q),
    .cos_term_i     (cos_term_q),
    .sin_term_i     (sin_term_q),
    .block_length_i (block_length_q),
    .real_part_o    (out_if.real_part),
    .imag_part_o    (out_if.imag_part)
  );

endmodule

`default_nettype wire
